FILE: src/clws_pkg.sv
// ----------------------------------------------------------------------------
// clws_pkg: shared types, codes and microprogram for the LCD write sequencer
// Holds the request codes, the control word layout and the read-only program.
// ----------------------------------------------------------------------------
`default_nettype none

package clws_pkg;

  // Default width of the number that the decimal print request converts
  localparam int NUMBER_WIDTH_DEF = 32;

  // Fixed field widths of the request and transfer channels
  localparam int OP_W     = 3;
  localparam int BYTE_W   = 8;
  localparam int ROW_W    = 2;
  localparam int COL_W    = 6;
  localparam int NUM_IN_W = 32;
  localparam int IN_DATA_W = 48;  // byte, row, column, number; whole bytes
  localparam int OUT_USER_W = 2;  // register_select, position_error

  // Configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] ADDR_MODE = 2'd0;

  // Request codes
  typedef enum logic [OP_W-1:0] {
    OP_INIT = 3'd0,
    OP_CMD  = 3'd1,
    OP_DATA = 3'd2,
    OP_POS  = 3'd3,
    OP_NUM  = 3'd4
  } op_t;

  // Step address
  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_INIT      = 4'd0;
  localparam pc_t PC_INIT4_A   = 4'd1;
  localparam pc_t PC_INIT4_B   = 4'd2;
  localparam pc_t PC_INIT4_C   = 4'd3;
  localparam pc_t PC_INIT8_A   = 4'd4;
  localparam pc_t PC_INIT8_B   = 4'd5;
  localparam pc_t PC_INIT8_C   = 4'd6;
  localparam pc_t PC_INIT_DISP = 4'd7;
  localparam pc_t PC_INIT_CLR  = 4'd8;
  localparam pc_t PC_CMD       = 4'd9;
  localparam pc_t PC_DATA      = 4'd10;
  localparam pc_t PC_POS       = 4'd11;
  localparam pc_t PC_NUM       = 4'd12;
  localparam pc_t PC_SKIP      = 4'd13;
  localparam pc_t PC_DIGIT     = 4'd14;

  // LCD command bytes and nibbles
  localparam logic [7:0] LCD_FUNC8    = 8'b0011_1100;
  localparam logic [7:0] LCD_DISP_CUR = 8'b0000_1110;
  localparam logic [7:0] LCD_DISP_ON  = 8'b0000_1100;
  localparam logic [7:0] LCD_CLEAR    = 8'b0000_0001;
  localparam logic [7:0] LCD_NIB_FUNC = 8'b0000_0010;
  localparam logic [7:0] LCD_NIB_LINE = 8'b0000_1100;
  localparam logic [7:0] LCD_SET_ADDR = 8'd128;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;  // upper nibble of '0'

  // Transfer kind of a step
  typedef enum logic [1:0] {
    K_NOP,
    K_NIB,
    K_BYTE
  } kind_t;

  // Byte source
  typedef enum logic [1:0] {
    S_CONST,
    S_BYTE,
    S_POS,
    S_DIGIT
  } src_t;

  // Datapath action at step completion
  typedef enum logic [1:0] {
    A_NONE,
    A_CONV,
    A_SKIP,
    A_NEXT
  } act_t;

  // Jump condition
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_EIGHT,
    C_CONV,
    C_LEADZERO,
    C_MORE
  } cond_t;

  // End-of-request condition
  typedef enum logic [1:0] {
    E_NONE,
    E_ALWAYS,
    E_LASTDIG
  } fin_t;

  typedef struct packed {
    kind_t      kind;
    src_t       src;
    logic       rs;
    logic [7:0] cval;
    act_t       act;
    cond_t      cond;
    fin_t       fin;
    pc_t        target;
  } cw_t;

  function automatic cw_t mk_cw(input kind_t kind, input src_t src, input logic rs,
                                input logic [7:0] cval, input act_t act,
                                input cond_t cond, input fin_t fin, input pc_t target);
    cw_t w;
    w.kind   = kind;
    w.src    = src;
    w.rs     = rs;
    w.cval   = cval;
    w.act    = act;
    w.cond   = cond;
    w.fin    = fin;
    w.target = target;
    return w;
  endfunction

  // Microprogram
  function automatic cw_t cw_rom(input pc_t pc);
    cw_t w;
    case (pc)
      PC_INIT:      w = mk_cw(K_NOP,  S_CONST, 1'b0, 8'h00, A_NONE, C_EIGHT,
                              E_NONE, PC_INIT8_A);
      PC_INIT4_A:   w = mk_cw(K_NIB,  S_CONST, 1'b0, LCD_NIB_FUNC, A_NONE, C_NONE,
                              E_NONE, PC_INIT);
      PC_INIT4_B:   w = mk_cw(K_NIB,  S_CONST, 1'b0, LCD_NIB_FUNC, A_NONE, C_NONE,
                              E_NONE, PC_INIT);
      PC_INIT4_C:   w = mk_cw(K_NIB,  S_CONST, 1'b0, LCD_NIB_LINE, A_NONE, C_ALWAYS,
                              E_NONE, PC_INIT_DISP);
      PC_INIT8_A:   w = mk_cw(K_BYTE, S_CONST, 1'b0, LCD_FUNC8, A_NONE, C_NONE,
                              E_NONE, PC_INIT);
      PC_INIT8_B:   w = mk_cw(K_BYTE, S_CONST, 1'b0, LCD_DISP_CUR, A_NONE, C_NONE,
                              E_NONE, PC_INIT);
      PC_INIT8_C:   w = mk_cw(K_BYTE, S_CONST, 1'b0, LCD_CLEAR, A_NONE, C_NONE,
                              E_NONE, PC_INIT);
      PC_INIT_DISP: w = mk_cw(K_BYTE, S_CONST, 1'b0, LCD_DISP_ON, A_NONE, C_NONE,
                              E_NONE, PC_INIT);
      PC_INIT_CLR:  w = mk_cw(K_BYTE, S_CONST, 1'b0, LCD_CLEAR, A_NONE, C_NONE,
                              E_ALWAYS, PC_INIT);
      PC_CMD:       w = mk_cw(K_BYTE, S_BYTE, 1'b0, 8'h00, A_NONE, C_NONE,
                              E_ALWAYS, PC_INIT);
      PC_DATA:      w = mk_cw(K_BYTE, S_BYTE, 1'b1, 8'h00, A_NONE, C_NONE,
                              E_ALWAYS, PC_INIT);
      PC_POS:       w = mk_cw(K_BYTE, S_POS, 1'b0, 8'h00, A_NONE, C_NONE,
                              E_ALWAYS, PC_INIT);
      PC_NUM:       w = mk_cw(K_NOP,  S_CONST, 1'b0, 8'h00, A_CONV, C_CONV,
                              E_NONE, PC_NUM);
      PC_SKIP:      w = mk_cw(K_NOP,  S_CONST, 1'b0, 8'h00, A_SKIP, C_LEADZERO,
                              E_NONE, PC_SKIP);
      PC_DIGIT:     w = mk_cw(K_BYTE, S_DIGIT, 1'b1, 8'h00, A_NEXT, C_MORE,
                              E_LASTDIG, PC_DIGIT);
      default:      w = mk_cw(K_NOP,  S_CONST, 1'b0, 8'h00, A_NONE, C_NONE,
                              E_ALWAYS, PC_INIT);
    endcase
    return w;
  endfunction

  // Decimal digits needed for the largest value of a given bit width
  function automatic int dec_digits(input int w);
    logic [63:0] v;
    int n;
    v = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    n = 0;
    do begin
      n++;
      v = v / 64'd10;
    end while (v != 64'd0);
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: src/char_lcd_write_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer: request to character LCD bus transfer sequencer
// Runs a small microprogram per request and emits one transaction per strobe.
// ----------------------------------------------------------------------------
// A request is taken only while no earlier request is still being sequenced;
// the last transfer may still wait in the output register. Transfers wait
// while the output side is not ready. Command, data and set position send
// one byte, split into two nibbles on a four-bit bus; init has one dispatch
// step plus five transfers (eight-bit) or seven (four-bit). Write number
// first converts the value with a shift-and-add-3 binary to BCD converter,
// one bit per step, then drops the leading zero digits, keeping at least
// one, and sends the remaining digits as ASCII data. A new request is
// accepted at the earliest in the cycle after the final step; output stalls
// can delay that step. Codes 5 to 7 are taken and produce nothing. There is
// no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_write_sequencer
  import clws_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Request channel
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // byte_value, row, column, number
  input  wire logic [OP_W-1:0]       in_tuser,   // operation
  // Transfer channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [BYTE_W-1:0]          out_tdata,  // bus_value
  output logic [OUT_USER_W-1:0]      out_tuser,  // register_select, position_error
  output logic                       out_tlast,
  // Configuration port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_AW-1:0]     cfg_paddr,
  input  wire logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]          cfg_prdata,
  output logic                       cfg_pready
);

  localparam int NDIG   = dec_digits(NUMBER_WIDTH);
  localparam int BCD_W  = 4 * NDIG;
  localparam int CCNT_W = $clog2(NUMBER_WIDTH + 1);
  localparam int DCNT_W = $clog2(NDIG + 1);

  // Registers
  logic                    busy_r, busy_nxt;
  pc_t                     pc_r, pc_nxt;
  logic                    nib_r, nib_nxt;
  logic                    four_bit_r, four_bit_nxt;
  logic [BYTE_W-1:0]       byte_r, byte_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic [NUMBER_WIDTH-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]        bcd_r, bcd_nxt;
  logic [CCNT_W-1:0]       ccnt_r, ccnt_nxt;
  logic [DCNT_W-1:0]       dcnt_r, dcnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_rs_r, out_rs_nxt;
  logic [BYTE_W-1:0]       out_bus_r, out_bus_nxt;
  logic                    out_err_r, out_err_nxt;
  logic                    out_last_r, out_last_nxt;

  // Decode
  cw_t               cw;
  logic              slot_free;
  logic [3:0]        top_dig;
  logic [BYTE_W-1:0] src_byte;
  logic              cond_true;
  logic              hi_phase;
  logic              emitting;
  logic              step_done;
  logic              is_end;
  logic              in_acc;
  logic              cfg_wr;
  logic [BCD_W-1:0]  bcd_adj;

  assign cw        = cw_rom(pc_r);
  assign slot_free = !out_valid_r || out_tready;
  assign top_dig   = bcd_r[BCD_W-1 -: 4];
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Select the byte the current step sends
  always_comb begin
    case (cw.src)
      S_CONST: src_byte = cw.cval;
      S_BYTE:  src_byte = byte_r;
      S_POS:   src_byte = row_r[1] ? LCD_SET_ADDR : {1'b1, row_r[0], col_r};
      S_DIGIT: src_byte = {ASCII_DIGIT_HI, top_dig};
      default: src_byte = cw.cval;
    endcase
  end

  // Evaluate the jump condition
  always_comb begin
    case (cw.cond)
      C_NONE:     cond_true = 1'b0;
      C_ALWAYS:   cond_true = 1'b1;
      C_EIGHT:    cond_true = !four_bit_r;
      C_CONV:     cond_true = ccnt_r > CCNT_W'(1);
      C_LEADZERO: cond_true = (top_dig == 4'd0) && (dcnt_r > DCNT_W'(1));
      C_MORE:     cond_true = dcnt_r > DCNT_W'(1);
      default:    cond_true = 1'b0;
    endcase
  end

  // End of request and step completion
  always_comb begin
    case (cw.fin)
      E_NONE:    is_end = 1'b0;
      E_ALWAYS:  is_end = 1'b1;
      E_LASTDIG: is_end = dcnt_r == DCNT_W'(1);
      default:   is_end = 1'b1;
    endcase
    hi_phase  = (cw.kind == K_BYTE) && four_bit_r && !nib_r;
    emitting  = busy_r && (cw.kind != K_NOP) && slot_free;
    step_done = busy_r && ((cw.kind == K_NOP) || (slot_free && !hi_phase));
  end

  // Add 3 to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? (bcd_r[4*i +: 4] + 4'd3)
                                                    : bcd_r[4*i +: 4];
    end
  end

  // Next state of sequencer and datapath
  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    nib_nxt       = nib_r;
    four_bit_nxt  = four_bit_r;
    byte_nxt      = byte_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    ccnt_nxt      = ccnt_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r;
    out_rs_nxt    = out_rs_r;
    out_bus_nxt   = out_bus_r;
    out_err_nxt   = out_err_r;
    out_last_nxt  = out_last_r;

    // Drop the transfer once taken
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // Load a transfer into the output register
    if (emitting) begin
      out_valid_nxt = 1'b1;
      out_rs_nxt    = cw.rs;
      out_err_nxt   = (cw.src == S_POS) && row_r[1];
      out_last_nxt  = is_end && !hi_phase;
      if (cw.kind == K_NIB) begin
        out_bus_nxt = {4'h0, cw.cval[3:0]};
      end else if (four_bit_r) begin
        out_bus_nxt = nib_r ? {4'h0, src_byte[3:0]} : {4'h0, src_byte[7:4]};
        nib_nxt     = !nib_r;
      end else begin
        out_bus_nxt = src_byte;
      end
    end

    // Advance, jump or finish
    if (step_done) begin
      if (is_end) begin
        busy_nxt = 1'b0;
      end else if (cond_true) begin
        pc_nxt = cw.target;
      end else begin
        pc_nxt = pc_r + pc_t'(1);
      end
      case (cw.act)
        A_CONV: begin
          bcd_nxt  = {bcd_adj[BCD_W-2:0], bin_r[NUMBER_WIDTH-1]};
          bin_nxt  = {bin_r[NUMBER_WIDTH-2:0], 1'b0};
          ccnt_nxt = ccnt_r - CCNT_W'(1);
        end
        A_SKIP: begin
          if (cond_true) begin
            bcd_nxt  = {bcd_r[BCD_W-5:0], 4'h0};
            dcnt_nxt = dcnt_r - DCNT_W'(1);
          end
        end
        A_NEXT: begin
          bcd_nxt  = {bcd_r[BCD_W-5:0], 4'h0};
          dcnt_nxt = dcnt_r - DCNT_W'(1);
        end
        default: begin
        end
      endcase
    end

    // Capture a new request
    if (in_acc) begin
      byte_nxt = in_tdata[7:0];
      row_nxt  = in_tdata[9:8];
      col_nxt  = in_tdata[15:10];
      bin_nxt  = NUMBER_WIDTH'(in_tdata[47:16]);
      bcd_nxt  = '0;
      ccnt_nxt = CCNT_W'(NUMBER_WIDTH);
      dcnt_nxt = DCNT_W'(NDIG);
      nib_nxt  = 1'b0;
      busy_nxt = 1'b1;
      case (op_t'(in_tuser))
        OP_INIT: pc_nxt = PC_INIT;
        OP_CMD:  pc_nxt = PC_CMD;
        OP_DATA: pc_nxt = PC_DATA;
        OP_POS:  pc_nxt = PC_POS;
        OP_NUM:  pc_nxt = PC_NUM;
        default: busy_nxt = 1'b0;
      endcase
    end

    // Register write
    if (cfg_wr) begin
      four_bit_nxt = cfg_pwdata[0];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= PC_INIT;
      nib_r       <= 1'b0;
      four_bit_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      nib_r       <= nib_nxt;
      four_bit_r  <= four_bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    ccnt_r     <= ccnt_nxt;
    dcnt_r     <= dcnt_nxt;
    out_rs_r   <= out_rs_nxt;
    out_bus_r  <= out_bus_nxt;
    out_err_r  <= out_err_nxt;
    out_last_r <= out_last_nxt;
  end

  // Ports
  assign in_tready  = !busy_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_bus_r;
  assign out_tuser  = {out_err_r, out_rs_r};
  assign out_tlast  = out_last_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_MODE) ? {{(CFG_DW-1){1'b0}}, four_bit_r}
                                               : '0;

endmodule

`default_nettype wire

FILE: tb/lcd_transfer_checker.sv
// ----------------------------------------------------------------------------
// lcd_transfer_checker: scoreboard for the character LCD write sequencer
// Watches the request, transfer and configuration channels, predicts the LCD
// bus transfers of every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module lcd_transfer_checker
  import clws_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // byte_value, row, column, number
  input  wire logic [OP_W-1:0]       in_tuser,   // operation
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [BYTE_W-1:0]     out_tdata,  // bus_value
  input  wire logic [OUT_USER_W-1:0] out_tuser,  // register_select, position_error
  input  wire logic                  out_tlast,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_AW-1:0]     cfg_paddr,
  input  wire logic [CFG_DW-1:0]     cfg_pwdata,
  input  wire logic                  cfg_pready,
  output int unsigned                mismatch_count,
  output int unsigned                outstanding,
  output int unsigned                transfers_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // LCD instruction bytes and nibbles used by the power-up sequence
  localparam logic [7:0] FUNC_SET_8BIT  = 8'h3C;
  localparam logic [7:0] DISPLAY_CURSOR = 8'h0E;
  localparam logic [7:0] DISPLAY_ON     = 8'h0C;
  localparam logic [7:0] CLEAR_DISPLAY  = 8'h01;
  localparam logic [7:0] NIBBLE_FUNC    = 8'h02;
  localparam logic [7:0] NIBBLE_LINES   = 8'h0C;
  localparam logic [7:0] DDRAM_BASE     = 8'h80;
  localparam logic [7:0] LINE_STRIDE    = 8'h40;
  localparam logic [7:0] ASCII_ZERO     = 8'h30;

  typedef struct packed {
    logic       rs;
    logic [7:0] bus;
    logic       err;
    logic       last;
  } lcd_xfer_t;

  lcd_xfer_t   expected_q[$];
  logic        nibble_mode;
  int unsigned errs;
  int unsigned checked;

  function automatic void queue_transfer(input logic rs, input logic [7:0] bus,
                                         input logic err);
    lcd_xfer_t x;
    x.rs   = rs;
    x.bus  = bus;
    x.err  = err;
    x.last = 1'b0;
    expected_q.push_back(x);
  endfunction

  // Split a byte into two nibbles, high half first, on a four-bit bus
  function automatic void queue_byte(input logic rs, input logic [7:0] value,
                                     input logic err);
    if (nibble_mode) begin
      queue_transfer(rs, {4'h0, value[7:4]}, err);
      queue_transfer(rs, {4'h0, value[3:0]}, err);
    end else begin
      queue_transfer(rs, value, err);
    end
  endfunction

  function automatic void predict_request(input logic [OP_W-1:0] op,
                                          input logic [7:0] value,
                                          input logic [1:0] row,
                                          input logic [5:0] col,
                                          input logic [31:0] num);
    int unsigned start_size;
    logic [3:0]  digits[10];
    int          nd;
    logic [31:0] rest;
    logic [7:0]  addr;
    lcd_xfer_t   tail;
    start_size = expected_q.size();
    case (op)
      OP_INIT: begin
        if (nibble_mode) begin
          queue_transfer(1'b0, NIBBLE_FUNC, 1'b0);
          queue_transfer(1'b0, NIBBLE_FUNC, 1'b0);
          queue_transfer(1'b0, NIBBLE_LINES, 1'b0);
        end else begin
          queue_byte(1'b0, FUNC_SET_8BIT, 1'b0);
          queue_byte(1'b0, DISPLAY_CURSOR, 1'b0);
          queue_byte(1'b0, CLEAR_DISPLAY, 1'b0);
        end
        queue_byte(1'b0, DISPLAY_ON, 1'b0);
        queue_byte(1'b0, CLEAR_DISPLAY, 1'b0);
      end
      OP_CMD:  queue_byte(1'b0, value, 1'b0);
      OP_DATA: queue_byte(1'b1, value, 1'b0);
      OP_POS: begin
        // A row past the second line falls back to address 0 and flags it
        if (row <= 2'd1) begin
          addr = DDRAM_BASE + LINE_STRIDE * {6'd0, row} + {2'b00, col};
          queue_byte(1'b0, addr, 1'b0);
        end else begin
          queue_byte(1'b0, DDRAM_BASE, 1'b1);
        end
      end
      OP_NUM: begin
        // Collect digits least significant first, send most significant first
        rest = num;
        nd = 0;
        do begin
          digits[nd] = 4'(rest % 32'd10);
          rest = rest / 32'd10;
          nd++;
        end while (rest != 32'd0);
        for (int i = nd - 1; i >= 0; i--) begin
          queue_byte(1'b1, ASCII_ZERO + {4'h0, digits[i]}, 1'b0);
        end
      end
      default: ;
    endcase
    // Mark the final transfer of this request
    if (expected_q.size() > start_size) begin
      tail = expected_q.pop_back();
      tail.last = 1'b1;
      expected_q.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin : monitor
    lcd_xfer_t want;
    lcd_xfer_t got;
    if (!rst_n) begin
      expected_q.delete();
      nibble_mode = 1'b1;
      errs = 0;
      checked = 0;
    end else begin
      // Track the bus width register
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == ADDR_MODE) begin
        nibble_mode = cfg_pwdata[0];
      end
      // Compare each transfer against the oldest prediction
      if (out_tvalid && out_tready) begin
        got.rs   = out_tuser[0];
        got.bus  = out_tdata;
        got.err  = out_tuser[1];
        got.last = out_tlast;
        if (expected_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected transfer: rs=%0b bus=%02h err=%0b last=%0b",
                   $time, got.rs, got.bus, got.err, got.last);
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (got != want) begin
            errs++;
            $display("%0t: transfer mismatch: expected rs=%0b bus=%02h err=%0b last=%0b, %s",
                     $time, want.rs, want.bus, want.err, want.last,
                     $sformatf("got rs=%0b bus=%02h err=%0b last=%0b",
                               got.rs, got.bus, got.err, got.last));
          end
        end
      end
      // Predict the transfers of an accepted request
      if (in_tvalid && in_tready) begin
        predict_request(in_tuser, in_tdata[7:0], in_tdata[9:8], in_tdata[15:10],
                        in_tdata[47:16]);
      end
    end
    mismatch_count    <= errs;
    outstanding       <= expected_q.size();
    transfers_checked <= checked;
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the character LCD write sequencer
// Drives directed and random display requests in both bus widths under three
// idle patterns, and reports the scoreboard's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import clws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Settling margin, well beyond the work of the longest request
  localparam int SETTLE_CYCLES = 80;
  localparam int LIMIT_CYCLES  = 500000;
  localparam int RANDOM_PER_MODE = 37;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // byte_value, row, column, number
  logic [OP_W-1:0]       in_tuser = '0;   // operation
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [BYTE_W-1:0]     out_tdata;       // bus_value
  logic [OUT_USER_W-1:0] out_tuser;       // register_select, position_error
  logic                  out_tlast;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr = '0;
  logic [CFG_DW-1:0]     cfg_pwdata = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned transfers_checked;
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;

  always #2 clk = ~clk;

  char_lcd_write_sequencer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  lcd_transfer_checker scoreboard (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_tdata          (in_tdata),
    .in_tuser          (in_tuser),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata),
    .out_tuser         (out_tuser),
    .out_tlast         (out_tlast),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_pready        (cfg_pready),
    .mismatch_count    (mismatch_count),
    .outstanding       (outstanding),
    .transfers_checked (transfers_checked)
  );

  // Stall the transfer side at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("testbench: timeout after %0d cycles, %0d transfers outstanding",
               cycle_count, outstanding);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Offer one request, idling first at random, and hold until accepted
  task automatic send_request(input logic [OP_W-1:0] op, input logic [7:0] value,
                              input logic [1:0] row, input logic [5:0] col,
                              input logic [31:0] num);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {num, col, row, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  // Drop valid and wait until every predicted transfer has come out
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Write the bus width register once the sequencer has gone idle
  task automatic set_bus_mode(input logic nibble);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_MODE;
    cfg_pwdata  <= {{(CFG_DW-1){1'b0}}, nibble};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic logic [31:0] pick_number();
    case ($urandom_range(3))
      0:       return 32'($urandom_range(99));
      1:       return $urandom;
      2:       return $urandom >> $urandom_range(31);
      default: return 32'hFFFF_FFFF - 32'($urandom_range(9));
    endcase
  endfunction

  // Random request; reserved codes are sent but not counted
  task automatic random_request(output bit counted);
    logic [OP_W-1:0] op;
    int              r;
    r = $urandom_range(99);
    counted = 1'b1;
    if (r < 5) begin
      op = OP_W'($urandom_range(OP_NUM + 1, (1 << OP_W) - 1));
      counted = 1'b0;
    end else if (r < 15) begin
      op = OP_INIT;
    end else if (r < 35) begin
      op = OP_CMD;
    end else if (r < 55) begin
      op = OP_DATA;
    end else if (r < 75) begin
      op = OP_POS;
    end else begin
      op = OP_NUM;
    end
    send_request(op, 8'($urandom), 2'($urandom), 6'($urandom), pick_number());
  endtask

  initial begin : stimulus
    bit counted;
    int done_items;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    snd_idle_pct = 20;
    rcv_idle_pct = 63;

    // Directed requests on the four-bit bus
    set_bus_mode(1'b1);
    send_request(OP_INIT, 8'h00, 2'd0, 6'd0, 32'd0);
    send_request(OP_CMD,  8'h00, 2'd0, 6'd0, 32'd0);
    send_request(OP_CMD,  8'hFF, 2'd3, 6'd63, 32'hFFFF_FFFF);
    send_request(OP_DATA, 8'h00, 2'd0, 6'd0, 32'd0);
    send_request(OP_DATA, 8'hFF, 2'd0, 6'd0, 32'd0);
    send_request(OP_POS,  8'h00, 2'd0, 6'd0, 32'd0);
    send_request(OP_POS,  8'hFF, 2'd1, 6'd63, 32'd0);
    send_request(OP_POS,  8'h00, 2'd0, 6'd63, 32'd0);
    send_request(OP_POS,  8'h00, 2'd2, 6'd5, 32'd0);
    send_request(OP_POS,  8'h00, 2'd3, 6'd63, 32'd0);
    send_request(OP_NUM,  8'h00, 2'd0, 6'd0, 32'd0);
    send_request(OP_NUM,  8'h00, 2'd0, 6'd0, 32'd9);
    send_request(OP_NUM,  8'h00, 2'd0, 6'd0, 32'd10);
    send_request(OP_NUM,  8'h00, 2'd0, 6'd0, 32'hFFFF_FFFF);
    send_request(OP_NUM,  8'h00, 2'd0, 6'd0, 32'd1_000_000_000);
    wait_for_results();
    for (int c = OP_NUM + 1; c < (1 << OP_W); c++) begin
      send_request(OP_W'(c), 8'($urandom), 2'($urandom), 6'($urandom), $urandom);
    end
    send_request(OP_NUM,  8'h00, 2'd0, 6'd0, 32'd4_000_000_000);

    // Directed requests on the eight-bit bus
    set_bus_mode(1'b0);
    send_request(OP_INIT, 8'h00, 2'd0, 6'd0, 32'd0);
    send_request(OP_CMD,  8'hA5, 2'd0, 6'd0, 32'd0);
    send_request(OP_DATA, 8'h5A, 2'd0, 6'd0, 32'd0);
    send_request(OP_POS,  8'h00, 2'd1, 6'd10, 32'd0);
    send_request(OP_POS,  8'h00, 2'd2, 6'd0, 32'd0);
    send_request(OP_NUM,  8'h00, 2'd0, 6'd0, 32'hFFFF_FFFF);
    send_request(OP_NUM,  8'h00, 2'd0, 6'd0, 32'd0);

    // Random requests: three idle patterns, each on both bus widths
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          snd_idle_pct = 20;
          rcv_idle_pct = 63;
        end
        1: begin
          snd_idle_pct = 63;
          rcv_idle_pct = 20;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      for (int m = 1; m >= 0; m--) begin
        set_bus_mode(m[0]);
        done_items = 0;
        while (done_items < RANDOM_PER_MODE) begin
          // Hold off at the halfway count until the pipeline empties
          if (done_items == RANDOM_PER_MODE / 2) begin
            wait_for_results();
          end
          random_request(counted);
          if (counted) done_items++;
        end
      end
    end

    // Let the last request drain, then report
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("testbench: %0d requests on four- and eight-bit buses, %0d transfers compared",
             requests_sent, transfers_checked);
    $display("testbench: covered init, bad rows, reserved codes, ten-digit numbers, stalls");
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
